@@ rtl/fme_pkg.sv @@
// Package for the Manchester frame encoder.
// Holds the byte kind codes, the queue entry and register file types, and the nibble coder.
// No dependencies.
package fme_pkg;

  localparam logic [2:0] KIND_PREAMBLE = 3'd0;
  localparam logic [2:0] KIND_START    = 3'd1;
  localparam logic [2:0] KIND_DATA     = 3'd2;
  localparam logic [2:0] KIND_CHECKSUM = 3'd3;
  localparam logic [2:0] KIND_END      = 3'd4;

  localparam logic [3:0] MaxPreamble = 4'd8;

  localparam logic [7:0] REG_PREAMBLE_COUNT = 8'd0;
  localparam logic [7:0] REG_PREAMBLE_BYTE  = 8'd1;
  localparam logic [7:0] REG_START_BYTE     = 8'd2;
  localparam logic [7:0] REG_END_BYTE       = 8'd3;

  typedef struct packed {
    logic [3:0] preamble_count;
    logic [7:0] preamble_byte;
    logic [7:0] start_byte;
    logic [7:0] end_byte;
  } cfg_t;

  typedef struct packed {
    logic [7:0] hi_code;
    logic [7:0] lo_code;
    logic [7:0] checksum;
    logic       frame_start;
    logic       frame_end;
  } entry_t;

  function automatic logic [7:0] manchester_nibble(input logic [3:0] nib);
    logic [7:0] code;
    code = '0;
    for (int j = 0; j < 4; j++) begin
      code[2*j +: 2] = nib[j] ? 2'b01 : 2'b10;
    end
    return code;
  endfunction

endpackage

@@ rtl/fme_front.sv @@
// Front end of the Manchester frame encoder.
// Accepts payload bytes, codes both nibbles and keeps the running checksum.
// Depends on fme_pkg.
module fme_front import fme_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // payload_byte
  input  logic [0:0] s_tuser,   // frame_start
  input  logic       s_tlast,   // frame_end
  output logic       push,
  output entry_t     push_entry,
  input  logic       queue_full
);

  logic [7:0] running_sum;
  logic [7:0] sum_base;
  logic [7:0] sum_next;
  logic [7:0] hi_code;
  logic [7:0] lo_code;

  assign s_tready = !queue_full;
  assign push     = s_tvalid && s_tready;

  assign hi_code  = manchester_nibble(s_tdata[7:4]);
  assign lo_code  = manchester_nibble(s_tdata[3:0]);
  assign sum_base = s_tuser[0] ? 8'd0 : running_sum;
  assign sum_next = 8'(sum_base + hi_code + lo_code);

  always_comb begin
    push_entry.hi_code     = hi_code;
    push_entry.lo_code     = lo_code;
    push_entry.checksum    = sum_next;
    push_entry.frame_start = s_tuser[0];
    push_entry.frame_end   = s_tlast;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
    end else if (push) begin
      running_sum <= s_tlast ? 8'd0 : sum_next;
    end
  end

endmodule

@@ rtl/fme_queue.sv @@
// Two-entry queue between the front and back ends of the frame encoder.
// Depends on fme_pkg for the entry type.
module fme_queue import fme_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   head_valid,
  output entry_t head_entry
);

  entry_t     entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_entry = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

@@ rtl/fme_back.sv @@
// Back end of the frame encoder: steps through the bytes of one queued entry.
// Emits preamble, start, coded data, checksum and end bytes into an output register.
// Depends on fme_pkg.
module fme_back import fme_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       head_valid,
  input  entry_t     head_entry,
  output logic       pop,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // out_byte
  output logic [2:0] m_tuser,   // byte_kind
  output logic       m_tlast    // run_last
);

  localparam logic [2:0] PH_FIRST = 3'd0;
  localparam logic [2:0] PH_PRE   = 3'd1;
  localparam logic [2:0] PH_START = 3'd2;
  localparam logic [2:0] PH_HI    = 3'd3;
  localparam logic [2:0] PH_LO    = 3'd4;
  localparam logic [2:0] PH_SUM   = 3'd5;
  localparam logic [2:0] PH_END   = 3'd6;

  logic [2:0] phase;
  logic [2:0] phase_next;
  logic [2:0] cur_phase;
  logic [3:0] pre_done;
  logic [3:0] pre_done_next;
  logic [3:0] npre;
  logic       emit;
  logic [7:0] byte_next;
  logic [2:0] kind_next;
  logic       last_next;

  assign npre = (cfg.preamble_count > MaxPreamble) ? MaxPreamble : cfg.preamble_count;
  assign emit = head_valid && (!m_tvalid || m_tready);
  assign pop  = emit && last_next;

  always_comb begin
    if (phase == PH_FIRST) begin
      if (head_entry.frame_start) begin
        cur_phase = (npre != 4'd0) ? PH_PRE : PH_START;
      end else begin
        cur_phase = PH_HI;
      end
    end else begin
      cur_phase = phase;
    end

    byte_next     = head_entry.hi_code;
    kind_next     = KIND_DATA;
    last_next     = 1'b0;
    phase_next    = cur_phase;
    pre_done_next = pre_done;

    case (cur_phase)
      PH_PRE: begin
        byte_next     = cfg.preamble_byte;
        kind_next     = KIND_PREAMBLE;
        pre_done_next = pre_done + 4'd1;
        phase_next    = (pre_done_next >= npre) ? PH_START : PH_PRE;
      end
      PH_START: begin
        byte_next  = cfg.start_byte;
        kind_next  = KIND_START;
        phase_next = PH_HI;
      end
      PH_HI: begin
        byte_next  = head_entry.hi_code;
        kind_next  = KIND_DATA;
        phase_next = PH_LO;
      end
      PH_LO: begin
        byte_next  = head_entry.lo_code;
        kind_next  = KIND_DATA;
        last_next  = !head_entry.frame_end;
        phase_next = head_entry.frame_end ? PH_SUM : PH_FIRST;
      end
      PH_SUM: begin
        byte_next  = head_entry.checksum;
        kind_next  = KIND_CHECKSUM;
        phase_next = PH_END;
      end
      PH_END: begin
        byte_next  = cfg.end_byte;
        kind_next  = KIND_END;
        last_next  = 1'b1;
        phase_next = PH_FIRST;
      end
      default: begin
        phase_next = PH_FIRST;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_FIRST;
      pre_done <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (emit) begin
        m_tvalid <= 1'b1;
        if (last_next) begin
          phase    <= PH_FIRST;
          pre_done <= '0;
        end else begin
          phase    <= phase_next;
          pre_done <= pre_done_next;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= byte_next;
      m_tuser <= kind_next;
      m_tlast <= last_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst) pop |=> m_tvalid && m_tlast)
    else $error("entry retired without a closing byte");

  assert property (@(posedge clk) disable iff (rst) (phase == PH_PRE) |-> (pre_done < npre))
    else $error("preamble run overran its count");

  assert property (@(posedge clk) disable iff (rst)
      (phase != PH_FIRST) |-> head_valid)
    else $error("sequencer is mid-entry with an empty queue");

  assert property (@(posedge clk) disable iff (rst)
      m_tvalid && (m_tuser == KIND_CHECKSUM) |-> !m_tlast)
    else $error("checksum byte marked as last of its run");

endmodule

@@ rtl/manchester_frame_encoder.sv @@
// Top level of the Manchester frame encoder: configuration registers, front, queue and back.
// Depends on fme_pkg, fme_front, fme_queue and fme_back.
//
// Each payload byte yields two Manchester coded bytes, plus the configured preamble bytes and
// the start byte when it opens a frame, and the checksum and end byte when it closes one. The
// output sequencer emits one byte per cycle while an entry is queued and the output is ready;
// the back-end sequencer is the limit. A two-entry queue lets the input keep accepting while
// the output stalls, until the queue is full. Configuration writes are always ready and take
// effect at once; they are meant to be done while no frame is in flight.
module manchester_frame_encoder import fme_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,    // payload_byte
  input  logic [0:0] s_tuser,    // frame_start
  input  logic       s_tlast,    // frame_end
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,    // out_byte
  output logic [2:0] m_tuser,    // byte_kind
  output logic       m_tlast,    // run_last
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data
);

  cfg_t   cfg;
  logic   push;
  entry_t push_entry;
  logic   queue_full;
  logic   pop;
  logic   head_valid;
  entry_t head_entry;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.preamble_count <= 4'd8;
      cfg.preamble_byte  <= 8'h55;
      cfg.start_byte     <= 8'hA4;
      cfg.end_byte       <= 8'hA0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PREAMBLE_COUNT: cfg.preamble_count <= cfg_data[3:0];
        REG_PREAMBLE_BYTE:  cfg.preamble_byte  <= cfg_data;
        REG_START_BYTE:     cfg.start_byte     <= cfg_data;
        REG_END_BYTE:       cfg.end_byte       <= cfg_data;
        default: ;
      endcase
    end
  end

  fme_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tlast    (s_tlast),
    .push       (push),
    .push_entry (push_entry),
    .queue_full (queue_full)
  );

  fme_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  fme_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

@@ verif/manchester_frame_encoder_test.sv @@
// Self-checking testbench for manchester_frame_encoder: directed frames, register corner
// cases and random framed traffic under changing backpressure, all checked per output byte.
// Depends on fme_pkg and the manchester_frame_encoder RTL.
module manchester_frame_encoder_test;
  import fme_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PREAMBLE_CAP = 8;
  localparam logic [7:0] NO_SUCH_REG = 8'hC7;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [7:0] value;
    logic [2:0] kind;
    logic       last;
  } line_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = '0;     // payload_byte
  logic [0:0] s_tuser = '0;     // frame_start
  logic       s_tlast = 1'b0;   // frame_end
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;          // out_byte
  logic [2:0] m_tuser;          // byte_kind
  logic       m_tlast;          // run_last
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  logic [3:0] cfg_count;
  logic [7:0] cfg_preamble;
  logic [7:0] cfg_start;
  logic [7:0] cfg_end;
  logic [7:0] frame_sum;

  line_byte_t line_bytes_due[$];
  int         mismatches = 0;
  int         send_idle_pct = 9;
  int         recv_idle_pct = 67;
  logic       out_taken = 1'b0;
  line_byte_t out_got;

  manchester_frame_encoder uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic logic [7:0] code_nibble(input logic [3:0] n);
    return {~n[3], n[3], ~n[2], n[2], ~n[1], n[1], ~n[0], n[0]};
  endfunction

  function automatic void queue_line_byte(input logic [7:0] value, input logic [2:0] kind,
                                          input logic last);
    line_byte_t b;
    b.value = value;
    b.kind = kind;
    b.last = last;
    line_bytes_due.push_back(b);
  endfunction

  function automatic void encode_frame_byte(input logic [7:0] payload, input logic first,
                                            input logic last);
    int         n;
    logic [7:0] hi;
    logic [7:0] lo;
    if (first) begin
      n = (cfg_count > PREAMBLE_CAP) ? PREAMBLE_CAP : cfg_count;
      frame_sum = '0;
      for (int i = 0; i < n; i++) queue_line_byte(cfg_preamble, KIND_PREAMBLE, 1'b0);
      queue_line_byte(cfg_start, KIND_START, 1'b0);
    end
    hi = code_nibble(payload[7:4]);
    lo = code_nibble(payload[3:0]);
    frame_sum = frame_sum + hi + lo;
    queue_line_byte(hi, KIND_DATA, 1'b0);
    queue_line_byte(lo, KIND_DATA, !last);
    if (last) begin
      queue_line_byte(frame_sum, KIND_CHECKSUM, 1'b0);
      queue_line_byte(cfg_end, KIND_END, 1'b1);
      frame_sum = '0;
    end
  endfunction

  function automatic void report_mismatch(input string what, input line_byte_t want,
                                          input line_byte_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("%0t %s: expected byte %h kind %0d last %b, got byte %h kind %0d last %b",
               $realtime, what, want.value, want.kind, want.last,
               got.value, got.kind, got.last);
  endfunction

  always @(negedge clk) begin
    out_taken = !rst && m_tvalid && m_tready;
    out_got = {m_tdata, m_tuser, m_tlast};
  end

  always @(posedge clk) begin
    if (out_taken) begin
      if (line_bytes_due.size() == 0) begin
        report_mismatch("unexpected output", '0, out_got);
      end else if (line_bytes_due[0] !== out_got) begin
        report_mismatch("wrong output", line_bytes_due[0], out_got);
        void'(line_bytes_due.pop_front());
      end else begin
        void'(line_bytes_due.pop_front());
      end
    end
  end

  task automatic send_byte(input logic [7:0] payload, input logic first, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= payload;
    s_tuser <= first;
    s_tlast <= last;
    do @(negedge clk); while (!s_tready);
    encode_frame_byte(payload, first, last);
    @(posedge clk);
  endtask

  task automatic wait_drained;
    s_tvalid <= 1'b0;
    while (line_bytes_due.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] index, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    case (index)
      REG_PREAMBLE_COUNT: cfg_count = value[3:0];
      REG_PREAMBLE_BYTE:  cfg_preamble = value;
      REG_START_BYTE:     cfg_start = value;
      REG_END_BYTE:       cfg_end = value;
      default: ;
    endcase
  endtask

  task automatic close_reg_writes;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] count, input logic [7:0] preamble,
                                input logic [7:0] start_mark, input logic [7:0] end_mark);
    write_reg(REG_PREAMBLE_COUNT, count);
    write_reg(REG_PREAMBLE_BYTE, preamble);
    write_reg(REG_START_BYTE, start_mark);
    write_reg(REG_END_BYTE, end_mark);
    close_reg_writes;
  endtask

  task automatic test_reset_defaults;
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'hA5, 1'b0, 1'b1);
    send_byte(8'h5A, 1'b1, 1'b1);
    wait_drained;
  endtask

  task automatic test_register_extremes;
    apply_settings(8'h00, 8'h00, 8'hFF, 8'h00);
    send_byte(8'h3C, 1'b1, 1'b1);
    wait_drained;
    // A count above eight is clamped to eight preamble bytes.
    apply_settings(8'hFF, 8'hFF, 8'h00, 8'hFF);
    send_byte(8'hC3, 1'b1, 1'b1);
    wait_drained;
    // Only the low four bits of the count are kept.
    apply_settings(8'hF3, 8'h81, 8'h7E, 8'h18);
    send_byte(8'h96, 1'b1, 1'b0);
    send_byte(8'h69, 1'b0, 1'b1);
    wait_drained;
  endtask

  task automatic test_unflagged_data;
    send_byte(8'h0F, 1'b0, 1'b0);
    send_byte(8'hF0, 1'b0, 1'b1);
    send_byte(8'h81, 1'b0, 1'b0);
    send_byte(8'h7E, 1'b1, 1'b0);
    send_byte(8'h18, 1'b0, 1'b1);
    wait_drained;
  endtask

  task automatic test_ignored_index;
    apply_settings(8'h01, 8'hAA, 8'h5B, 8'hC6);
    write_reg(NO_SUCH_REG, 8'h00);
    close_reg_writes;
    send_byte(8'h42, 1'b1, 1'b1);
    wait_drained;
  endtask

  task automatic random_frames(input int budget);
    int sent;
    int len;
    int pick;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(9);
      len = $urandom_range(6, 1);
      for (int i = 0; i < len; i++) begin
        if (pick < 7)
          send_byte(8'($urandom_range(255)), i == 0, i == len - 1);
        else if (pick == 7)
          send_byte(8'($urandom_range(255)), 1'b0, 1'b0);
        else
          send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
      sent += len;
    end
  endtask

  task automatic test_random_traffic;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 67 : 0;
      recv_idle_pct = (phase == 0) ? 67 : (phase == 1) ? 9 : 0;
      if (phase == 2)
        apply_settings(8'h08, 8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(255)));
      else
        apply_settings(8'($urandom_range(15)), 8'($urandom_range(255)),
                       8'($urandom_range(255)), 8'($urandom_range(255)));
      random_frames(45);
      wait_drained;
    end
  endtask

  initial begin
    cfg_count = 4'd8;
    cfg_preamble = 8'h55;
    cfg_start = 8'hA4;
    cfg_end = 8'hA0;
    frame_sum = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults;
    test_register_extremes;
    test_unflagged_data;
    test_ignored_index;
    test_random_traffic;
    wait_drained;
    repeat (20) @(posedge clk);
    if (mismatches == 0 && line_bytes_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #600000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
